@@ sv/ptc_pkg.sv @@
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, stage counts and arithmetic helpers for the pressure and
// temperature compensation pipeline.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int FRONT_STAGES = 12;
  localparam int DIV_BITS     = 64;
  localparam int DIV_STAGES   = DIV_BITS + 2;
  localparam int BACK_STAGES  = 5;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + BACK_STAGES;

  typedef enum logic [1:0] {
    REG_CAL_TEMP    = 2'd0,
    REG_CAL_PRESS_A = 2'd1,
    REG_CAL_PRESS_B = 2'd2,
    REG_CAL_PRESS_C = 2'd3
  } ptc_reg_t;

  typedef struct packed {
    logic [31:0] fine;
    logic [31:0] centi;
  } ptc_temp_t;

  // 32-bit word times 17-bit signed coefficient, exact
  function automatic logic signed [49:0] mul_p(input logic [31:0] x,
                                               input logic signed [16:0] c);
    mul_p = $signed({1'b0, x}) * c;
  endfunction

  // rebuild a 64-bit wrapped product from its low and high word partials
  function automatic logic [63:0] join_p(input logic signed [49:0] lo,
                                         input logic signed [49:0] hi);
    join_p = 64'(lo) + {hi[31:0], 32'h0};
  endfunction

endpackage

@@ sv/ptc_ifs.sv @@
// ----------------------------------------------------------------------------
// ptc channel interfaces
// Valid/ready channels for raw sample words and compensated result words.
// ----------------------------------------------------------------------------
interface ptc_in_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, output raw_temperature, output raw_pressure, input ready);
  modport sink (input valid, input raw_temperature, input raw_pressure, output ready);
endinterface

interface ptc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] fine_temperature;
  logic signed [31:0] temperature_centi;
  logic        [31:0] pressure_q24_8;
  logic               pressure_valid;
  modport source (output valid, output fine_temperature, output temperature_centi,
                  output pressure_q24_8, output pressure_valid, input ready);
  modport sink (input valid, input fine_temperature, input temperature_centi,
                input pressure_q24_8, input pressure_valid, output ready);
endinterface

@@ sv/pressure_temperature_compensation_core.sv @@
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_core
// Integer barometric compensation: fine temperature, centi-degrees and
// pressure in Q24.8 from raw 20-bit samples and packed calibration words.
//
//   channel  dir  handshake                 word
//   in_if    in   valid/ready               raw_temperature, raw_pressure
//   out_if   out  valid/ready               fine, centi, pressure, valid flag
//   cfg_*    in   apb write, pready tied 1  cal_temp, cal_press_a/b/c
//
// one word per cycle sustained while the output is not stalled
// reset clears all stage valid bits and the calibration registers
// a stalled output holds every full stage; empty stages still fill while stalled
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_core import ptc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  ptc_in_if.sink      in_if,
  ptc_out_if.source   out_if,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [47:0] cal_temp_r;
  logic [63:0] cal_press_a_r;
  logic [63:0] cal_press_b_r;
  logic [15:0] cal_press_c_r;
  ptc_reg_t    reg_sel;

  assign reg_sel    = ptc_reg_t'(cfg_paddr[4:3]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r    <= '0;
      cal_press_a_r <= '0;
      cal_press_b_r <= '0;
      cal_press_c_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (reg_sel)
        REG_CAL_TEMP:    cal_temp_r    <= cfg_pwdata[47:0];
        REG_CAL_PRESS_A: cal_press_a_r <= cfg_pwdata;
        REG_CAL_PRESS_B: cal_press_b_r <= cfg_pwdata;
        REG_CAL_PRESS_C: cal_press_c_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CAL_TEMP:    cfg_prdata = 64'(cal_temp_r);
      REG_CAL_PRESS_A: cfg_prdata = cal_press_a_r;
      REG_CAL_PRESS_B: cfg_prdata = cal_press_b_r;
      REG_CAL_PRESS_C: cfg_prdata = 64'(cal_press_c_r);
      default:         cfg_prdata = '0;
    endcase
  end

  logic [PIPE_STAGES-1:0] en;
  logic [63:0]            num, den, quo;
  logic                   dz;
  ptc_temp_t              t_front, t_div, t_out;
  logic [31:0]            pressure;
  logic                   press_ok;

  ptc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .en        (en)
  );

  ptc_frontend u_front (
    .clk             (clk),
    .en              (en[FRONT_STAGES-1:0]),
    .raw_temperature (in_if.raw_temperature),
    .raw_pressure    (in_if.raw_pressure),
    .cal_temp        (cal_temp_r),
    .cal_press_a     (cal_press_a_r),
    .cal_press_b_lo  (cal_press_b_r[31:0]),
    .num             (num),
    .den             (den),
    .temp            (t_front)
  );

  ptc_div u_div (
    .clk    (clk),
    .en     (en[FRONT_STAGES +: DIV_STAGES]),
    .num    (num),
    .den    (den),
    .sb_in  (t_front),
    .quo    (quo),
    .dz     (dz),
    .sb_out (t_div)
  );

  ptc_back u_back (
    .clk         (clk),
    .en          (en[FRONT_STAGES + DIV_STAGES +: BACK_STAGES]),
    .quo         (quo),
    .dz          (dz),
    .sb_in       (t_div),
    .cal_press_b (cal_press_b_r),
    .cal_press_c (cal_press_c_r),
    .temp        (t_out),
    .pressure    (pressure),
    .press_ok    (press_ok)
  );

  assign out_if.fine_temperature  = t_out.fine;
  assign out_if.temperature_centi = t_out.centi;
  assign out_if.pressure_q24_8    = pressure;
  assign out_if.pressure_valid    = press_ok;

endmodule

@@ sv/ptc_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptc_ctrl
// Per-stage valid bits and load enables; bubbles close up one stage a cycle.
// ----------------------------------------------------------------------------
module ptc_ctrl import ptc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [PIPE_STAGES-1:0] en
);

  logic [PIPE_STAGES-1:0] v_r;
  logic [PIPE_STAGES-1:0] v_nxt;
  logic                   go;

  assign go        = !v_r[PIPE_STAGES-1] || out_ready;
  assign in_ready  = en[0];
  assign out_valid = v_r[PIPE_STAGES-1];

  always_comb begin
    for (int i = 0; i < PIPE_STAGES; i++) begin
      en[i] = go || !v_r[i];
    end
    for (int i = 0; i < PIPE_STAGES; i++) begin
      if (en[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end else if (i < PIPE_STAGES - 1 && en[(i < PIPE_STAGES - 1) ? i + 1 : i]) begin
        v_nxt[i] = 1'b0;
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

endmodule

@@ sv/ptc_front.sv @@
// ----------------------------------------------------------------------------
// ptc_front
// Front-end stages of the compensation pipeline are built in ptc_frontend.
// ----------------------------------------------------------------------------

@@ sv/ptc_div.sv @@
// ----------------------------------------------------------------------------
// ptc_div
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating.
// ----------------------------------------------------------------------------
module ptc_div import ptc_pkg::*; (
  input  logic                  clk,
  input  logic [DIV_STAGES-1:0] en,
  input  logic [63:0]           num,
  input  logic [63:0]           den,
  input  ptc_temp_t             sb_in,
  output logic [63:0]           quo,
  output logic                  dz,
  output ptc_temp_t             sb_out
);

  logic [63:0] rem_r [0:DIV_BITS-1];
  logic [63:0] nq_r  [0:DIV_BITS];
  logic [63:0] md_r  [0:DIV_BITS-1];
  logic        neg_r [0:DIV_BITS];
  logic        dz_r  [0:DIV_BITS];
  ptc_temp_t   sb_r  [0:DIV_BITS];
  logic [63:0] quo_r;
  logic        dzo_r;
  ptc_temp_t   sbo_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0] <= '0;
      nq_r[0]  <= num[63] ? 64'h0 - num : num;
      md_r[0]  <= den[63] ? 64'h0 - den : den;
      neg_r[0] <= num[63] ^ den[63];
      dz_r[0]  <= (den == 64'h0);
      sb_r[0]  <= sb_in;
    end
  end

  for (genvar k = 1; k <= DIV_BITS; k++) begin : g_bit
    logic [63:0] t;
    logic        ge;
    assign t  = {rem_r[k-1][62:0], nq_r[k-1][63]};
    assign ge = (t >= md_r[k-1]);
    always_ff @(posedge clk) begin
      if (en[k]) begin
        nq_r[k]  <= {nq_r[k-1][62:0], ge};
        neg_r[k] <= neg_r[k-1];
        dz_r[k]  <= dz_r[k-1];
        sb_r[k]  <= sb_r[k-1];
      end
    end
    if (k < DIV_BITS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en[k]) begin
          rem_r[k] <= ge ? t - md_r[k-1] : t;
          md_r[k]  <= md_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[DIV_STAGES-1]) begin
      quo_r <= neg_r[DIV_BITS] ? 64'h0 - nq_r[DIV_BITS] : nq_r[DIV_BITS];
      dzo_r <= dz_r[DIV_BITS];
      sbo_r <= sb_r[DIV_BITS];
    end
  end

  assign quo    = quo_r;
  assign dz     = dzo_r;
  assign sb_out = sbo_r;

endmodule

@@ sv/ptc_back.sv @@
// ----------------------------------------------------------------------------
// ptc_back
// Second-order pressure correction, offset, clamp and result register.
// ----------------------------------------------------------------------------
module ptc_back import ptc_pkg::*; (
  input  logic                   clk,
  input  logic [BACK_STAGES-1:0] en,
  input  logic [63:0]            quo,
  input  logic                   dz,
  input  ptc_temp_t              sb_in,
  input  logic [63:0]            cal_press_b,
  input  logic [15:0]            cal_press_c,
  output ptc_temp_t              temp,
  output logic [31:0]            pressure,
  output logic                   press_ok
);

  logic signed [15:0] p7, p8, p9;
  assign p7 = cal_press_b[47:32];
  assign p8 = cal_press_b[63:48];
  assign p9 = cal_press_c;

  logic        dz_r [0:BACK_STAGES-2];
  ptc_temp_t   sb_r [0:BACK_STAGES-1];
  logic [63:0] p_r  [0:BACK_STAGES-3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      dz_r[0] <= dz;
      sb_r[0] <= sb_in;
      p_r[0]  <= quo;
    end
  end

  for (genvar k = 1; k < BACK_STAGES; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (en[k]) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  for (genvar k = 1; k < BACK_STAGES - 1; k++) begin : g_dcarry
    always_ff @(posedge clk) begin
      if (en[k]) begin
        dz_r[k] <= dz_r[k-1];
      end
    end
  end

  for (genvar k = 1; k < BACK_STAGES - 2; k++) begin : g_pcarry
    always_ff @(posedge clk) begin
      if (en[k]) begin
        p_r[k] <= p_r[k-1];
      end
    end
  end

  // stage 0: square of p>>13 and p8 partials
  logic        [63:0] ph;
  logic        [63:0] lolo_r;
  logic        [31:0] lohi_r;
  logic signed [49:0] p8lo_r, p8hi_r;

  assign ph = $signed(quo) >>> 13;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      lolo_r <= 64'(ph[31:0]) * 64'(ph[31:0]);
      lohi_r <= ph[31:0] * ph[63:32];
      p8lo_r <= mul_p(quo[31:0], {p8[15], p8});
      p8hi_r <= mul_p(quo[63:32], {p8[15], p8});
    end
  end

  // stage 1
  logic [63:0] sq_r;
  logic [63:0] v2_r [1:2];
  logic [63:0] x8;

  assign x8 = join_p(p8lo_r, p8hi_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sq_r    <= lolo_r + {lohi_r[30:0], 33'h0};
      v2_r[1] <= $signed(x8) >>> 19;
    end
  end

  // stage 2: p9 partials
  logic signed [49:0] p9lo_r, p9hi_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p9lo_r  <= mul_p(sq_r[31:0], {p9[15], p9});
      p9hi_r  <= mul_p(sq_r[63:32], {p9[15], p9});
      v2_r[2] <= v2_r[1];
    end
  end

  // stage 3
  logic [63:0] x9;
  logic [63:0] v1b;
  logic [63:0] s_r;

  assign x9  = join_p(p9lo_r, p9hi_r);
  assign v1b = $signed(x9) >>> 25;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s_r <= p_r[2] + v1b + v2_r[2];
    end
  end

  // stage 4: offset and clamp
  logic [63:0] r;
  logic [31:0] press_r;
  logic        ok_r;

  assign r = 64'($signed(s_r) >>> 8) + (64'(p7) << 4);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      if (dz_r[3]) begin
        press_r <= '0;
        ok_r    <= 1'b0;
      end else begin
        ok_r <= 1'b1;
        if (r[63]) begin
          press_r <= '0;
        end else if (r[63:32] != 32'h0) begin
          press_r <= 32'hFFFF_FFFF;
        end else begin
          press_r <= r[31:0];
        end
      end
    end
  end

  assign temp     = sb_r[BACK_STAGES-1];
  assign pressure = press_r;
  assign press_ok = ok_r;

endmodule

@@ sv/ptc_frontend.sv @@
// ----------------------------------------------------------------------------
// ptc_frontend
// Temperature terms, fine temperature and the pressure dividend and divisor.
// ----------------------------------------------------------------------------
module ptc_frontend import ptc_pkg::*; (
  input  logic                    clk,
  input  logic [FRONT_STAGES-1:0] en,
  input  logic [19:0]             raw_temperature,
  input  logic [19:0]             raw_pressure,
  input  logic [47:0]             cal_temp,
  input  logic [63:0]             cal_press_a,
  input  logic [31:0]             cal_press_b_lo,
  output logic [63:0]             num,
  output logic [63:0]             den,
  output ptc_temp_t               temp
);

  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;

  assign t1 = cal_temp[15:0];
  assign t2 = cal_temp[31:16];
  assign t3 = cal_temp[47:32];
  assign p1 = cal_press_a[15:0];
  assign p2 = cal_press_a[31:16];
  assign p3 = cal_press_a[47:32];
  assign p4 = cal_press_a[63:48];
  assign p5 = cal_press_b_lo[15:0];
  assign p6 = cal_press_b_lo[31:16];

  logic [19:0] rt_r;
  logic [19:0] rp_r [0:8];
  ptc_temp_t   tsb_r [4:11];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rt_r     <= raw_temperature;
      rp_r[0]  <= raw_pressure;
    end
  end

  for (genvar k = 1; k <= 8; k++) begin : g_rp
    always_ff @(posedge clk) begin
      if (en[k]) begin
        rp_r[k] <= rp_r[k-1];
      end
    end
  end

  for (genvar k = 5; k <= 11; k++) begin : g_tsb
    always_ff @(posedge clk) begin
      if (en[k]) begin
        tsb_r[k] <= tsb_r[k-1];
      end
    end
  end

  // stage 1: first temperature products
  logic signed [17:0] a;
  logic signed [16:0] b;
  logic signed [33:0] m1_full, bb_full;
  logic        [31:0] m1_r, bb_r;

  assign a       = $signed({1'b0, rt_r[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign b       = $signed({1'b0, rt_r[19:4]}) - $signed({1'b0, t1});
  assign m1_full = a * t2;
  assign bb_full = b * b;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      m1_r <= m1_full[31:0];
      bb_r <= bb_full[31:0];
    end
  end

  // stage 2
  logic signed [47:0] m2_full;
  logic        [31:0] tv1_r, m2_r;

  assign m2_full = ($signed(bb_r) >>> 12) * t3;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      tv1_r <= $signed(m1_r) >>> 11;
      m2_r  <= m2_full[31:0];
    end
  end

  // stage 3: fine temperature
  logic [31:0] fine_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      fine_r <= tv1_r + 32'($signed(m2_r) >>> 14);
    end
  end

  // stage 4: centi-degrees and pressure offset term
  logic        [31:0] f5;
  logic signed [32:0] v1_r;

  assign f5 = (fine_r << 2) + fine_r + 32'd128;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      tsb_r[4].fine  <= fine_r;
      tsb_r[4].centi <= $signed(f5) >>> 8;
      v1_r           <= $signed({fine_r[31], fine_r}) - 33'sd128000;
    end
  end

  // stage 5
  logic signed [65:0] sq_full;
  logic        [63:0] sq_r;
  logic signed [48:0] pv2_r [5:7];
  logic signed [48:0] pv5_r [5:7];

  assign sq_full = v1_r * v1_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sq_r     <= sq_full[63:0];
      pv2_r[5] <= v1_r * p2;
      pv5_r[5] <= v1_r * p5;
    end
  end

  for (genvar k = 6; k <= 7; k++) begin : g_pv
    always_ff @(posedge clk) begin
      if (en[k]) begin
        pv2_r[k] <= pv2_r[k-1];
        pv5_r[k] <= pv5_r[k-1];
      end
    end
  end

  // stage 6: p6 and p3 partials of the square
  logic signed [49:0] l6_r, h6_r, l3_r, h3_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      l6_r <= mul_p(sq_r[31:0], {p6[15], p6});
      h6_r <= mul_p(sq_r[63:32], {p6[15], p6});
      l3_r <= mul_p(sq_r[31:0], {p3[15], p3});
      h3_r <= mul_p(sq_r[63:32], {p3[15], p3});
    end
  end

  // stage 7
  logic [63:0] x6_r, x3_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      x6_r <= join_p(l6_r, h6_r);
      x3_r <= join_p(l3_r, h3_r);
    end
  end

  // stage 8
  logic [63:0] v2_r;
  logic [63:0] va_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      v2_r <= x6_r + (64'(pv5_r[7]) << 17) + (64'(p4) << 35);
      va_r <= 64'($signed(x3_r) >>> 8) + (64'(pv2_r[7]) << 12);
    end
  end

  // stage 9: p1 partials and dividend base
  logic        [63:0] b47;
  logic        [20:0] pnum;
  logic signed [49:0] l1_r, h1_r;
  logic        [63:0] d_r;

  assign b47  = 64'h0000_8000_0000_0000 + va_r;
  assign pnum = 21'd1048576 - {1'b0, rp_r[8]};

  always_ff @(posedge clk) begin
    if (en[9]) begin
      l1_r <= mul_p(b47[31:0], {1'b0, p1});
      h1_r <= mul_p(b47[63:32], {1'b0, p1});
      d_r  <= (64'(pnum) << 31) - v2_r;
    end
  end

  // stage 10
  logic        [63:0] bj;
  logic        [63:0] den_r [10:11];
  logic signed [49:0] ld_r, hd_r;

  assign bj = join_p(l1_r, h1_r);

  always_ff @(posedge clk) begin
    if (en[10]) begin
      den_r[10] <= $signed(bj) >>> 33;
      ld_r      <= mul_p(d_r[31:0], 17'sd3125);
      hd_r      <= mul_p(d_r[63:32], 17'sd3125);
    end
  end

  // stage 11
  logic [63:0] num_r;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      num_r     <= join_p(ld_r, hd_r);
      den_r[11] <= den_r[10];
    end
  end

  assign num  = num_r;
  assign den  = den_r[11];
  assign temp = tsb_r[11];

endmodule

@@ sv/ptc_checker.sv @@
// ----------------------------------------------------------------------------
// ptc_checker
// Port-level checks on the compensation core, bound to the top level.
// ----------------------------------------------------------------------------
module ptc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] fine,
  input logic [31:0] pressure,
  input logic        press_ok,
  input logic        cfg_pready
);

  // held word stays up
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(fine) && $stable(pressure))
    else $error("result word changed while stalled");

  // zero divisor forces pressure to zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !press_ok |-> pressure == 32'h0)
    else $error("invalid pressure not zero");

  // an empty output register never blocks intake
  assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_if.ready),
  .out_valid  (out_if.valid),
  .out_ready  (out_if.ready),
  .fine       (out_if.fine_temperature),
  .pressure   (out_if.pressure_q24_8),
  .press_ok   (out_if.pressure_valid),
  .cfg_pready (cfg_pready)
);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the compensation core: drives raw sample words
// with random gaps, stalls the result channel, rewrites the calibration
// registers between phases and checks every result word in order against a
// local integer model of the compensation formulas.
// ----------------------------------------------------------------------------
module tb import ptc_pkg::*; ();

  typedef struct packed {
    logic signed [31:0] fine;
    logic signed [31:0] centi;
    logic        [31:0] press;
    logic               pvalid;
  } comp_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  ptc_in_if  in_if();
  ptc_out_if out_if();

  pressure_temperature_compensation_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #1 clk = ~clk;

  logic [47:0] cal_temp_q = '0;
  logic [63:0] cal_press_a_q = '0;
  logic [63:0] cal_press_b_q = '0;
  logic [15:0] cal_press_c_q = '0;

  comp_word_t expected_words[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.raw_temperature = '0;
    in_if.raw_pressure = '0;
    out_if.ready = 1'b0;
  end

  function automatic comp_word_t compensate(logic [19:0] rt, logic [19:0] rp);
    int t1, t2, t3, a, b, s, tv1, tv2, fine, centi;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, ph, num;
    comp_word_t r;
    t1 = int'({16'h0, cal_temp_q[15:0]});
    t2 = int'($signed(cal_temp_q[31:16]));
    t3 = int'($signed(cal_temp_q[47:32]));
    a = int'({12'h0, rt} >> 3) - (t1 <<< 1);
    tv1 = (a * t2) >>> 11;
    b = int'({12'h0, rt} >> 4) - t1;
    s = (b * b) >>> 12;
    tv2 = (s * t3) >>> 14;
    fine = tv1 + tv2;
    centi = (fine * 5 + 128) >>> 8;
    p1 = longint'({48'h0, cal_press_a_q[15:0]});
    p2 = longint'($signed(cal_press_a_q[31:16]));
    p3 = longint'($signed(cal_press_a_q[47:32]));
    p4 = longint'($signed(cal_press_a_q[63:48]));
    p5 = longint'($signed(cal_press_b_q[15:0]));
    p6 = longint'($signed(cal_press_b_q[31:16]));
    p7 = longint'($signed(cal_press_b_q[47:32]));
    p8 = longint'($signed(cal_press_b_q[63:48]));
    p9 = longint'($signed(cal_press_c_q));
    v1 = longint'(fine) - 128000;
    v2 = v1 * v1 * p6 + ((v1 * p5) <<< 17) + (p4 <<< 35);
    v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
    v1 = (((longint'(1) <<< 47) + v1) * p1) >>> 33;
    r.fine = fine;
    r.centi = centi;
    r.press = '0;
    r.pvalid = 1'b0;
    if (v1 != 0) begin
      p = 1048576 - longint'({44'h0, rp});
      num = ((p <<< 31) - v2) * 3125;
      if (num == (longint'(1) <<< 63) && v1 == -1) p = num;
      else p = num / v1;
      ph = p >>> 13;
      v1 = (p9 * ph * ph) >>> 25;
      v2 = (p8 * p) >>> 19;
      p = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
      if (p < 0) r.press = '0;
      else if (p > 64'sh0_FFFF_FFFF) r.press = 32'hFFFF_FFFF;
      else r.press = p[31:0];
      r.pvalid = 1'b1;
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
  endtask

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    comp_word_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_words.size() == 0) begin
        report("unexpected result word", out_if.fine_temperature, 32'h0);
      end else begin
        w = expected_words.pop_front();
        if (out_if.fine_temperature !== w.fine)
          report("fine_temperature", out_if.fine_temperature, w.fine);
        if (out_if.temperature_centi !== w.centi)
          report("temperature_centi", out_if.temperature_centi, w.centi);
        if (out_if.pressure_q24_8 !== w.press)
          report("pressure_q24_8", out_if.pressure_q24_8, w.press);
        if (out_if.pressure_valid !== w.pvalid)
          report("pressure_valid", {31'h0, out_if.pressure_valid}, {31'h0, w.pvalid});
      end
    end
  end

  task automatic send_word(logic [19:0] rt, logic [19:0] rp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.raw_temperature <= rt;
    in_if.raw_pressure <= rp;
    do @(posedge clk); while (!in_if.ready);
    expected_words.push_back(compensate(rt, rp));
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    go_idle();
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(ptc_reg_t idx, logic [63:0] value);
    logic [63:0] want;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 3'b000};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    unique case (idx)
      REG_CAL_TEMP: begin
        cal_temp_q = value[47:0];
        want = 64'(cal_temp_q);
      end
      REG_CAL_PRESS_A: begin
        cal_press_a_q = value;
        want = cal_press_a_q;
      end
      REG_CAL_PRESS_B: begin
        cal_press_b_q = value;
        want = cal_press_b_q;
      end
      REG_CAL_PRESS_C: begin
        cal_press_c_q = value[15:0];
        want = 64'(cal_press_c_q);
      end
    endcase
    @(negedge clk);
    if (cfg_prdata !== want)
      report("register readback", cfg_prdata[31:0], want[31:0]);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_cal(logic [63:0] ct, logic [63:0] pa, logic [63:0] pb,
                          logic [63:0] pc);
    drain();
    write_reg(REG_CAL_TEMP, ct);
    write_reg(REG_CAL_PRESS_A, pa);
    write_reg(REG_CAL_PRESS_B, pb);
    write_reg(REG_CAL_PRESS_C, pc);
  endtask

  function automatic logic [15:0] jitter(int base);
    return 16'(base + $signed($urandom_range(400)) - 200);
  endfunction

  task automatic load_typical_cal();
    load_cal({16'h0, jitter(-1000), jitter(26435), jitter(27504)},
             {jitter(2855), jitter(3024), jitter(-10685), jitter(36477)},
             {jitter(-14600), jitter(15500), jitter(-7), jitter(140)},
             {48'h0, jitter(6000)});
  endtask

  task automatic load_random_cal();
    int sel;
    logic [63:0] pa;
    sel = $urandom_range(9);
    pa = {$urandom, $urandom};
    if (sel < 6) begin
      load_typical_cal();
    end else if (sel < 8) begin
      load_cal({$urandom, $urandom}, pa, {$urandom, $urandom}, {$urandom, $urandom});
    end else if (sel < 9) begin
      pa[15:0] = '0;
      load_cal({$urandom, $urandom}, pa, {$urandom, $urandom}, {$urandom, $urandom});
    end else begin
      load_cal({64{1'($urandom_range(1))}}, {64{1'($urandom_range(1))}},
               {64{1'($urandom_range(1))}}, {64{1'($urandom_range(1))}});
    end
  endtask

  task automatic send_random_word();
    if ($urandom_range(3) != 0)
      send_word(20'(519888 + $signed($urandom_range(200000)) - 100000),
                20'(415148 + $signed($urandom_range(200000)) - 100000));
    else
      send_word(20'($urandom), 20'($urandom));
  endtask

  task automatic test_directed();
    logic [19:0] corners[4] = '{20'h00000, 20'hFFFFF, 20'h80000, 20'h7FFFF};
    load_cal({16'h0, 16'hFC18, 16'd26435, 16'd27504},
             {16'd2855, 16'd3024, 16'hD643, 16'd36477},
             {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 64'd6000);
    send_word(20'd519888, 20'd415148);
    foreach (corners[i]) send_word(corners[i], corners[3 - i]);
    // zero divisor: p1 cleared, temperature still reported
    load_cal(64'(cal_temp_q), 64'h0, cal_press_b_q, 64'(cal_press_c_q));
    send_word(20'd519888, 20'd415148);
    send_word(20'hFFFFF, 20'h0);
    // every calibration word at its extremes
    load_cal(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
             64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
    foreach (corners[i]) send_word(corners[i], corners[i]);
    load_cal(64'h8000_8000_FFFF, 64'h7FFF_7FFF_7FFF_FFFF,
             64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF);
    foreach (corners[i]) send_word(corners[i], corners[3 - i]);
    load_cal(64'h7FFF_7FFF_0000, 64'h8000_8000_8000_0001,
             64'h8000_8000_8000_8000, 64'h8000);
    foreach (corners[i]) send_word(corners[i], corners[i]);
    // pressure clamp high and low
    load_cal({16'h0, 16'd0, 16'd0, 16'd0}, {16'h7FFF, 16'h0, 16'h0, 16'd1},
             {16'h0, 16'h7FFF, 16'h0, 16'h0}, 64'h0);
    send_word(20'h0, 20'h0);
    load_cal(64'(cal_temp_q), cal_press_a_q, {16'h0, 16'h8000, 16'h0, 16'h0}, 64'h0);
    send_word(20'h0, 20'hFFFFF);
  endtask

  task automatic test_random_phase(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) load_random_cal();
      send_random_word();
    end
  endtask

  task automatic test_backpressure();
    load_typical_cal();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles = 400;
    repeat (150) send_random_word();
    // sender waits for the pipeline to empty
    drain();
    repeat (20) send_random_word();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_phase(400, 10, 76);
    test_random_phase(400, 76, 10);
    test_random_phase(400, 0, 0);
    test_backpressure();
    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
